// ===== rtl/dksm_pkg.sv =====
package dksm_pkg;

  // store geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  // request and response field widths
  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [CMD_W-1:0]           cmd_t;
  typedef logic signed [KEY_W-1:0]    key_t;
  typedef logic [VALUE_W-1:0]         value_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [OCC_W-1:0]           occ_t;

  // command codes
  localparam cmd_t CMD_PUSH_BACK  = cmd_t'(0);
  localparam cmd_t CMD_PUSH_FRONT = cmd_t'(1);
  localparam cmd_t CMD_POP_FRONT  = cmd_t'(2);
  localparam cmd_t CMD_POP_BACK   = cmd_t'(3);
  localparam cmd_t CMD_SEARCH     = cmd_t'(4);
  localparam cmd_t CMD_UPDATE     = cmd_t'(5);
  localparam cmd_t CMD_COUNT      = cmd_t'(6);
  localparam cmd_t CMD_MAX        = cmd_t'(7);

  // status codes
  localparam status_t ST_OK        = status_t'(0);
  localparam status_t ST_EMPTY     = status_t'(1);
  localparam status_t ST_NOT_FOUND = status_t'(2);
  localparam status_t ST_FULL      = status_t'(3);

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic decode;
    logic pop_take;
    logic walk_step;
    logic upd_write;
    logic load_out;
  } dksm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_live;
    logic walk_live;
    logic is_update;
    logic walk_end;
    logic hit;
    logic out_free;
  } dksm_stat_t;

endpackage

// ===== rtl/dksm_if.sv =====
interface dksm_in_if import dksm_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  key_t   item_key;
  value_t item_value;

  modport source (output valid, output cmd, output item_key, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_key, input item_value, output ready);
endinterface

interface dksm_out_if import dksm_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  key_t    found_key;
  value_t  found_value;
  count_t  entry_count;

  modport source (output valid, output status, output found_key, output found_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_key, input found_value,
                  input entry_count, output ready);
endinterface

// ===== rtl/deque_keyed_search_max_top.sv =====
// deque_keyed_search_max_top: bounded double-ended queue of key/value entries
// held in a ring store of DEPTH slots (DEPTH = 16 here).
// req_ch (sink): one request per handshake; cmd selects push back, push front,
//   pop front, pop back, search, update, count or max; item_key and item_value
//   carry the operands. a request is taken when valid and ready are both high.
// rsp_ch (source): exactly one response per request, in request order, with
//   status, found_key, found_value and entry_count (occupancy after the request).
// sequencing: an accepted request is decoded; a pop then takes its entry from
//   the store, search, max and update walk the occupied entries from the
//   front, and an update that hits writes its new value; the result is then
//   loaded into the output register. a search or update stops at the first key
//   match. the walk reads one store entry per cycle through a single registered
//   read port. one request is in flight at a time: the controller returns to
//   idle only after the last result is loaded, and takes the next there.
// the response sits in an output register, so the next request is taken
//   while an earlier response still waits; when the receiver stalls the
//   finished response holds and the block waits before loading the next one.
// reset (rst, synchronous, active high) empties the queue and drops any
//   pending response; store contents are not cleared, and only entries of
//   occupied slots are ever used.
module deque_keyed_search_max_top import dksm_pkg::*; (
  input logic        clk,
  input logic        rst,
  dksm_in_if.sink    req_ch,
  dksm_out_if.source rsp_ch
);

  dksm_cmd_t  cmd;   // sequencing strobes into the datapath
  dksm_stat_t stat;  // request class and walk progress back to the controller

  // controller: accepts a request, steps decode, pop read, walk, update write,
  // then waits for the output register to be free
  dksm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_ch.valid),
    .in_ready (req_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: ring store, front pointer and occupancy, walk comparators,
  // and the response register
  dksm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (req_ch.cmd),
    .in_key     (req_ch.item_key),
    .in_value   (req_ch.item_value),
    .out_valid  (rsp_ch.valid),
    .out_ready  (rsp_ch.ready),
    .out_status (rsp_ch.status),
    .out_key    (rsp_ch.found_key),
    .out_value  (rsp_ch.found_value),
    .out_count  (rsp_ch.entry_count)
  );

endmodule

// ===== rtl/dksm_ctrl.sv =====
module dksm_ctrl import dksm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dksm_stat_t stat,
  output dksm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.pop_live)       state_next = S_POP;
        else if (stat.walk_live) state_next = S_WALK;
        else                     state_next = S_DONE;
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_next   = S_DONE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_end) begin
          state_next = (stat.is_update && stat.hit) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.upd_write = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/dksm_dp.sv =====
module dksm_dp import dksm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dksm_cmd_t cmd,
  output dksm_stat_t stat,
  input  cmd_t      in_cmd,
  input  key_t      in_key,
  input  value_t    in_value,
  output logic      out_valid,
  input  logic      out_ready,
  output status_t   out_status,
  output key_t      out_key,
  output value_t    out_value,
  output count_t    out_count
);

  function automatic idx_t slot_of(idx_t base, occ_t p);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(p);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return IDX_W'(s);
  endfunction

  // ring store
  key_t   key_mem [DEPTH];
  value_t val_mem [DEPTH];

  // request latch
  cmd_t   cmd_q;
  key_t   key_q;
  value_t val_q;

  // deque pointers
  idx_t front;
  occ_t occ;

  // walk state
  occ_t   pos;
  logic   rd_vld;
  idx_t   rd_slot;
  key_t   rd_key;
  value_t rd_val;
  logic   hit;
  idx_t   hit_slot;
  key_t   hit_key;
  value_t hit_val;
  logic   best_any;
  key_t   best_key;
  value_t best_val;

  // pending result
  status_t res_status;
  key_t    res_key;
  value_t  res_val;

  logic   full, empty, is_push, is_pop, walk_end, issue;
  idx_t   front_inc, front_dec, pop_slot, raddr, waddr;
  logic   key_we, val_we;
  value_t wval;

  assign full      = (occ == OCC_W'(DEPTH));
  assign empty     = (occ == '0);
  assign is_push   = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT);
  assign is_pop    = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_BACK);
  assign front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + IDX_W'(1);
  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
  assign pop_slot  = (cmd_q == CMD_POP_FRONT) ? front : slot_of(front, occ - OCC_W'(1));
  assign raddr     = cmd.decode ? pop_slot : slot_of(front, pos);
  assign issue     = cmd.walk_step && (pos < occ);
  assign walk_end  = hit || (!rd_vld && (pos >= occ));

  assign key_we = cmd.decode && is_push && !full;
  assign val_we = key_we || cmd.upd_write;
  assign waddr  = cmd.upd_write ? hit_slot :
                  (cmd_q == CMD_PUSH_BACK) ? slot_of(front, occ) : front_dec;
  assign wval   = val_q;

  assign stat.pop_live  = is_pop && !empty;
  assign stat.walk_live = ((cmd_q == CMD_SEARCH) || (cmd_q == CMD_MAX) ||
                           (cmd_q == CMD_UPDATE)) && !empty;
  assign stat.is_update = (cmd_q == CMD_UPDATE);
  assign stat.walk_end  = walk_end;
  assign stat.hit       = hit;
  assign stat.out_free  = !out_valid || out_ready;

  // store ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (key_we) key_mem[waddr] <= key_q;
    if (val_we) val_mem[waddr] <= wval;
    rd_key  <= key_mem[raddr];
    rd_val  <= val_mem[raddr];
    rd_slot <= raddr;
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
      val_q <= in_value;
    end
  end

  // pointers and walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      front  <= '0;
      occ    <= '0;
      pos    <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else if (cmd.latch) begin
      // a new request drops the match flag of the previous one
      hit <= 1'b0;
    end else if (cmd.decode) begin
      pos    <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
      if (is_push && !full) begin
        occ <= occ + OCC_W'(1);
        if (cmd_q == CMD_PUSH_FRONT) front <= front_dec;
      end
      if (is_pop && !empty) begin
        occ <= occ - OCC_W'(1);
        if (cmd_q == CMD_POP_FRONT) front <= front_inc;
      end
    end else if (cmd.walk_step) begin
      rd_vld <= issue;
      if (issue) pos <= pos + OCC_W'(1);
      if (rd_vld && !hit && (cmd_q != CMD_MAX) && (rd_key == key_q)) hit <= 1'b1;
    end
  end

  // match and maximum capture
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      best_any <= 1'b0;
    end else if (cmd.walk_step && rd_vld) begin
      if (!hit && (rd_key == key_q)) begin
        hit_slot <= rd_slot;
        hit_key  <= rd_key;
        hit_val  <= rd_val;
      end
      if (!best_any || (rd_val > best_val)) begin
        best_any <= 1'b1;
        best_key <= rd_key;
        best_val <= rd_val;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_status <= ST_OK;
      res_key    <= '0;
      res_val    <= '0;
      unique case (cmd_q) inside
        CMD_PUSH_BACK, CMD_PUSH_FRONT: if (full) res_status <= ST_FULL;
        CMD_POP_FRONT, CMD_POP_BACK, CMD_SEARCH, CMD_MAX: begin
          if (empty) res_status <= ST_EMPTY;
        end
        CMD_UPDATE: if (empty) res_status <= ST_NOT_FOUND;
        default: ;
      endcase
    end else if (cmd.pop_take) begin
      res_key <= rd_key;
      res_val <= rd_val;
    end else if (cmd.walk_step && walk_end) begin
      if (cmd_q == CMD_MAX) begin
        res_key <= best_key;
        res_val <= best_val;
      end else if (hit) begin
        res_key <= hit_key;
        res_val <= hit_val;
      end else begin
        res_status <= ST_NOT_FOUND;
      end
    end else if (cmd.upd_write) begin
      res_key <= hit_key;
      res_val <= val_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_value  <= res_val;
      out_count  <= COUNT_W'(occ);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy beyond store depth");

  a_occ_only_on_decode: assert property (@(posedge clk) disable iff (rst)
    !cmd.decode |=> $stable(occ) && $stable(front))
    else $error("pointers moved outside decode");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken response");

  a_hit_only_keyed: assert property (@(posedge clk) disable iff (rst)
    hit |-> ((cmd_q == CMD_SEARCH) || (cmd_q == CMD_UPDATE)))
    else $error("key match flagged for a non keyed command");

endmodule

// ===== tb/sv/deque_keyed_search_max_top_test.sv =====
module deque_keyed_search_max_top_test import dksm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // quiet cycles after the last response, longer than the slowest request
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    status_t status;
    key_t    key;
    value_t  value;
    count_t  count;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst;

  dksm_in_if  req_ch ();
  dksm_out_if rsp_ch ();

  deque_keyed_search_max_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the deque, kept in step with every accepted request
  key_t   shadow_keys [DEPTH];
  value_t shadow_values [DEPTH];
  int     shadow_head = 0;
  int     shadow_fill = 0;

  deque_rsp_t pending_rsp_q [$];
  int         fail_count = 0;

  // idling switches, cleared for the quiet tail of the run
  bit req_gap_en = 1'b1;
  bit rsp_stall_en = 1'b1;

  // a small key pool so that searches and updates hit, duplicates included
  key_t key_pool [8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
                         32'sh0000_0005, 32'sh0000_0011, -32'sd77, 32'sh1234_5678};

  function automatic int slot_of(int pos);
    return (shadow_head + pos) % DEPTH;
  endfunction

  // first slot from the front holding the key, or -1
  function automatic int find_slot(key_t k);
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_keys[slot_of(i)] == k) return slot_of(i);
    end
    return -1;
  endfunction

  // work out the response to one request and move the shadow deque on
  function automatic deque_rsp_t predict_deque(cmd_t c, key_t k, value_t v);
    deque_rsp_t r;
    int         s;
    int         best;
    r.status = ST_OK;
    r.key    = '0;
    r.value  = '0;
    case (c)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c == CMD_PUSH_BACK) begin
            s = slot_of(shadow_fill);
          end else begin
            shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
            s = shadow_head;
          end
          shadow_keys[s]   = k;
          shadow_values[s] = v;
          shadow_fill++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c == CMD_POP_FRONT) begin
            s = shadow_head;
            shadow_head = slot_of(1);
          end else begin
            s = slot_of(shadow_fill - 1);
          end
          r.key   = shadow_keys[s];
          r.value = shadow_values[s];
          shadow_fill--;
        end
      end
      CMD_SEARCH: begin
        s = find_slot(k);
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.key   = shadow_keys[s];
          r.value = shadow_values[s];
        end
      end
      CMD_UPDATE: begin
        s = find_slot(k);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          shadow_values[s] = v;
          r.key   = shadow_keys[s];
          r.value = v;
        end
      end
      CMD_COUNT: begin
      end
      default: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // strict compare keeps the earliest entry on a tie
          best = shadow_head;
          for (int i = 1; i < shadow_fill; i++) begin
            if (shadow_values[slot_of(i)] > shadow_values[best]) best = slot_of(i);
          end
          r.key   = shadow_keys[best];
          r.value = shadow_values[best];
        end
      end
    endcase
    r.count = count_t'(shadow_fill);
    return r;
  endfunction

  // one request: optional gap, then hold valid until the block takes it
  task automatic send_request(cmd_t c, key_t k, value_t v);
    if (req_gap_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c;
    req_ch.item_key   <= k;
    req_ch.item_value <= v;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp_q.push_back(predict_deque(c, k, v));
  endtask

  // hold off the sender until every response is back
  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp_q.size() != 0);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // response checker, sampled at the edge where the handshake completes
  always @(posedge clk) begin
    deque_rsp_t exp_rsp;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: response with none expected, expected nothing actual status %0d",
                 $time, rsp_ch.status);
        fail_count++;
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        check_field("status", 32'(exp_rsp.status), 32'(rsp_ch.status));
        check_field("found_key", exp_rsp.key, rsp_ch.found_key);
        check_field("found_value", exp_rsp.value, rsp_ch.found_value);
        check_field("entry_count", 32'(exp_rsp.count), 32'(rsp_ch.entry_count));
      end
    end
  end

  // receiver: bursts of ready and of stall, one drive per burst
  initial begin
    forever begin
      if (rsp_stall_en && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  function automatic value_t pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0100 << $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // mostly pool keys so entries collide, sometimes a fully random pattern
  function automatic key_t pick_push_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // mostly keys that are held right now, otherwise pool or random misses
  function automatic key_t pick_lookup_key();
    if (shadow_fill > 0 && $urandom_range(0, 3) != 0)
      return shadow_keys[slot_of($urandom_range(0, shadow_fill - 1))];
    return pick_push_key();
  endfunction

  // every command but the pushes on an empty deque
  task automatic test_empty_store();
    send_request(CMD_POP_FRONT, 32'sd0, 32'h0);
    send_request(CMD_POP_BACK, 32'sd0, 32'h0);
    send_request(CMD_SEARCH, 32'sh8000_0000, 32'h0);
    send_request(CMD_UPDATE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_MAX, 32'sd0, 32'h0);
    send_request(CMD_COUNT, 32'sd0, 32'h0);
  endtask

  // fill from both ends to capacity, refused pushes, ties and duplicate keys
  task automatic test_full_store();
    send_request(CMD_PUSH_BACK, 32'sh8000_0000, 32'h0000_0000);
    send_request(CMD_PUSH_FRONT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    // same maximum further back: the front one must win the tie
    send_request(CMD_PUSH_BACK, 32'sh0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_PUSH_BACK, -32'sd1, 32'h0000_0100);
    for (int i = 4; i < DEPTH; i++) begin
      send_request((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, key_t'(i % 3),
                   value_t'(i) << 8);
    end
    send_request(CMD_PUSH_BACK, 32'sh1234_5678, 32'h5A5A_5A5A);
    send_request(CMD_PUSH_FRONT, 32'sh1234_5678, 32'hA5A5_A5A5);
    send_request(CMD_MAX, 32'sd0, 32'h0);
    // key 1 sits several times, the front-most match counts
    send_request(CMD_SEARCH, 32'sd1, 32'h0);
    send_request(CMD_UPDATE, 32'sd1, 32'hFFFF_FFFF);
    send_request(CMD_MAX, 32'sd0, 32'h0);
    send_request(CMD_POP_FRONT, 32'sd0, 32'h0);
    send_request(CMD_POP_BACK, 32'sd0, 32'h0);
  endtask

  // biased random traffic; the bias swings so the deque runs full and empty
  task automatic run_random_traffic(int n_items, int drain_every);
    int   push_pct;
    int   pop_pct;
    int   roll;
    cmd_t c;
    key_t k;
    push_pct = 30;
    pop_pct  = 25;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_pct = 65; pop_pct = 10; end
          1: begin push_pct = 10; pop_pct = 65; end
          default: begin push_pct = 30; pop_pct = 25; end
        endcase
      end
      if (drain_every > 0 && n > 0 && n % drain_every == 0) wait_for_responses();
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        k = pick_push_key();
      end else if (roll < push_pct + pop_pct) begin
        c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        k = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: c = CMD_SEARCH;
          1: c = CMD_UPDATE;
          2: c = CMD_COUNT;
          default: c = CMD_MAX;
        endcase
        k = pick_lookup_key();
      end
      send_request(c, k, pick_value());
    end
  endtask

  task automatic test_random_traffic();
    run_random_traffic(950, 200);
  endtask

  // back-to-back requests with the receiver always ready
  task automatic test_quiet_tail();
    wait_for_responses();
    req_gap_en   = 1'b0;
    rsp_stall_en = 1'b0;
    run_random_traffic(150, 0);
  endtask

  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_COUNT;
    req_ch.item_key   <= '0;
    req_ch.item_value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_full_store();
    test_random_traffic();
    test_quiet_tail();

    // drain, then leave room for a stray late response
    wait_for_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
